@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Implication checked in the following cycle, ignored while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/emd_pkg.sv @@
// Shared types, widths and calendar constants for the elapsed-minutes block.
package emd_pkg;

    localparam int YearW    = 7;
    localparam int MonthW   = 4;
    localparam int MdayW    = 5;
    localparam int HourW    = 5;
    localparam int MinuteW  = 6;
    localparam int DayNumW  = 16;
    localparam int MonDaysW = 9;
    localparam int ElapsedW = 26;
    localparam int InDataW  = 56;
    localparam int OutDataW = 32;

    localparam logic [8:0]  DaysPerYear = 9'd365;
    localparam logic [10:0] MinPerDay   = 11'd1440;
    localparam logic [5:0]  MinPerHour  = 6'd60;
    localparam logic [YearW-1:0] YearOff2100 = 7'd100;
    localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};

    // One timestamp; year sits in the lowest bits.
    typedef struct packed {
        logic [MinuteW-1:0] minute;
        logic [HourW-1:0]   hour;
        logic [MdayW-1:0]   mday;
        logic [MonthW-1:0]  month;
        logic [YearW-1:0]   year;
    } ts_t;

    typedef struct packed {
        logic                end_before_begin;
        logic [ElapsedW-1:0] elapsed_minutes;
    } res_t;

    // Days of whole months before the given month in a common year.
    // Months past December count 30 days each beyond the full year.
    function automatic logic [MonDaysW-1:0] days_before_month(input logic [MonthW-1:0] mon);
        logic [MonDaysW-1:0] d;
        case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            4'd14:   d = 9'd395;
            default: d = 9'd425;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/core/emd_day_number.sv @@
// Day number of one timestamp: whole years since 2000, months, day of month.
module emd_day_number
(
    input  emd_pkg::ts_t                   ts,
    output logic [emd_pkg::DayNumW-1:0]    day_num
);

    logic [emd_pkg::YearW:0]         yoff_p3;
    logic [emd_pkg::YearW-2:0]       leaps;
    logic [emd_pkg::DayNumW-1:0]     year_days;
    logic                            leap_year;
    logic [emd_pkg::MonDaysW-1:0]    month_days;

    always_comb
    begin
        // leap years in 2000 .. 2000+yoff-1; 2100 is the only century miss in range
        yoff_p3   = {1'b0, ts.year} + 8'd3;
        leaps     = yoff_p3[emd_pkg::YearW:2] - {5'd0, (ts.year > emd_pkg::YearOff2100)};
        year_days = 16'(ts.year) * 16'(emd_pkg::DaysPerYear);
        leap_year = (ts.year[1:0] == 2'b00) && (ts.year != emd_pkg::YearOff2100);
        month_days = emd_pkg::days_before_month(ts.month)
                   + {8'd0, (ts.month > 4'd2) && leap_year};
        day_num   = year_days + 16'(leaps) + 16'(month_days) + 16'(ts.mday);
    end

endmodule

@@ rtl/core/emd_minute_diff.sv @@
// Minute difference between two day numbers plus times of day, with flag and saturation.
module emd_minute_diff
(
    input  logic [emd_pkg::DayNumW-1:0]  end_day,
    input  logic [emd_pkg::DayNumW-1:0]  begin_day,
    input  logic [emd_pkg::HourW-1:0]    end_hour,
    input  logic [emd_pkg::MinuteW-1:0]  end_minute,
    input  logic [emd_pkg::HourW-1:0]    begin_hour,
    input  logic [emd_pkg::MinuteW-1:0]  begin_minute,
    output emd_pkg::res_t                res
);

    logic                             day_neg;
    logic [emd_pkg::DayNumW-1:0]      day_diff;
    logic [emd_pkg::ElapsedW:0]       end_total;
    logic [10:0]                      begin_total;
    logic                             min_neg;
    logic [emd_pkg::ElapsedW:0]       min_diff;

    always_comb
    begin
        day_neg     = end_day < begin_day;
        day_diff    = end_day - begin_day;
        end_total   = 27'(day_diff) * 27'(emd_pkg::MinPerDay)
                    + 27'(end_hour) * 27'(emd_pkg::MinPerHour) + 27'(end_minute);
        begin_total = 11'(begin_hour) * 11'(emd_pkg::MinPerHour) + 11'(begin_minute);
        min_neg     = end_total < 27'(begin_total);
        min_diff    = end_total - 27'(begin_total);

        res.end_before_begin = day_neg || min_neg;
        if (day_neg || min_neg)
        begin
            res.elapsed_minutes = '0;
        end
        else if (min_diff[emd_pkg::ElapsedW])
        begin
            res.elapsed_minutes = emd_pkg::ElapsedMax;
        end
        else
        begin
            res.elapsed_minutes = min_diff[emd_pkg::ElapsedW-1:0];
        end
    end

endmodule

@@ rtl/core/elapsed_minutes_between_dates.sv @@
// Top level: minutes elapsed between two calendar timestamps, stream in and out.
//
// Input channel s_axis_*: one beat carries both timestamps (end, then begin),
// each as year from 2000, month, day of month, hour, minute.
// Output channel m_axis_*: one beat per input beat, in order. tdata holds the
// elapsed minutes (saturated to 26 bits); tuser is set when the end lies before
// the begin, and then the minute count is zero.
// Path: the accepting edge loads the input register; the result register is
// loaded from it once the output is free, and drives m_axis_tvalid and the
// output data.
// Throughput: one beat per cycle while the receiver keeps m_axis_tready high;
// the whole computation is a single pass of constant multiplies and adds between the two registers.
// Stall: when the receiver holds m_axis_tready low, the result stays on the
// output unchanged; the input register still takes one more beat, after which
// s_axis_tready drops until the output drains.
// Reset: rst_n clears both valid bits; no result is shown and the input is
// ready as soon as reset is released.
module elapsed_minutes_between_dates
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // end_year, end_month, end_mday, end_hour, end_minute, begin_year,
    // begin_month, begin_mday, begin_hour, begin_minute, 2 bits zero
    input  logic [emd_pkg::InDataW-1:0]     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // elapsed_minutes, 6 bits zero
    output logic [emd_pkg::OutDataW-1:0]    m_axis_tdata,
    // end_before_begin
    output logic                            m_axis_tuser
);

    logic                           in_valid_reg;
    logic                           in_valid_next;
    emd_pkg::ts_t                   end_ts_reg;
    emd_pkg::ts_t                   begin_ts_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    emd_pkg::res_t                  res_reg;
    emd_pkg::res_t                  res_next;
    logic                           out_load;
    logic                           in_load;
    logic [emd_pkg::DayNumW-1:0]    end_day;
    logic [emd_pkg::DayNumW-1:0]    begin_day;

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign in_load       = !in_valid_reg || out_load;
    assign s_axis_tready = in_load;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
        begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && s_axis_tvalid)
        begin
            end_ts_reg   <= s_axis_tdata[26:0];
            begin_ts_reg <= s_axis_tdata[53:27];
        end
        if (out_load)
        begin
            res_reg <= res_next;
        end
    end

    emd_day_number u_end_day
    (
        .ts      (end_ts_reg),
        .day_num (end_day)
    );

    emd_day_number u_begin_day
    (
        .ts      (begin_ts_reg),
        .day_num (begin_day)
    );

    emd_minute_diff u_diff
    (
        .end_day      (end_day),
        .begin_day    (begin_day),
        .end_hour     (end_ts_reg.hour),
        .end_minute   (end_ts_reg.minute),
        .begin_hour   (begin_ts_reg.hour),
        .begin_minute (begin_ts_reg.minute),
        .res          (res_next)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(emd_pkg::OutDataW - emd_pkg::ElapsedW){1'b0}},
                            res_reg.elapsed_minutes};
    assign m_axis_tuser  = res_reg.end_before_begin;

endmodule

@@ rtl/core/emd_checker.sv @@
// Port-level checks for the elapsed-minutes block, bound to the top level.
`include "assert_macros.svh"

module emd_port_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [emd_pkg::OutDataW-1:0]    m_axis_tdata,
    input logic                            m_axis_tuser
);

    // a flagged beat carries no minutes
    `ASSERT_CLK(a_flag_zero, clk, rst_n,
        !(m_axis_tvalid && m_axis_tuser) || (m_axis_tdata[emd_pkg::ElapsedW-1:0] == '0))
    // padding above the minute count stays clear
    `ASSERT_CLK(a_pad_zero, clk, rst_n,
        !m_axis_tvalid || (m_axis_tdata[emd_pkg::OutDataW-1:emd_pkg::ElapsedW] == '0))
    // input backpressure only comes from a stalled full output
    `ASSERT_CLK(a_ready_low, clk, rst_n,
        s_axis_tready || (m_axis_tvalid && !m_axis_tready))
    // a stalled result holds
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind elapsed_minutes_between_dates emd_port_checker u_emd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
